@@ design/rgb888_uyvy_color_converter_top_macros.svh @@
// Assertion macros for the color converter port checker.
// Each macro clocks on the given edge and is disabled while reset is low.
`ifndef RGB888_UYVY_COLOR_CONVERTER_TOP_MACROS_SVH
`define RGB888_UYVY_COLOR_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication.
`define RYC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define RYC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

@@ design/ryc_pkg.sv @@
// Shared types and constants for the RGB888 / UYVY pixel pair converter.
// No dependencies.
`default_nettype none

package ryc_pkg;

	localparam int PIX_W = 8;
	localparam int PAIR_BYTES = 6;

	// Conversion direction codes
	localparam logic DIR_RGB_TO_UYVY = 1'b0;
	localparam logic DIR_UYVY_TO_RGB = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [PAIR_BYTES-1:0] pair_t;

endpackage

`default_nettype wire

@@ design/ryc_in_if.sv @@
// Input channel of the converter: one pixel pair and its frame-end flag.
// Uses ryc_pkg for the byte type.
`default_nettype none

interface ryc_in_if;
	logic valid;
	logic ready;
	ryc_pkg::pix_t in_0;
	ryc_pkg::pix_t in_1;
	ryc_pkg::pix_t in_2;
	ryc_pkg::pix_t in_3;
	ryc_pkg::pix_t in_4;
	ryc_pkg::pix_t in_5;
	logic frame_end;

	modport source (output valid, in_0, in_1, in_2, in_3, in_4, in_5, frame_end,
		input ready);
	modport sink (input valid, in_0, in_1, in_2, in_3, in_4, in_5, frame_end,
		output ready);
endinterface

`default_nettype wire

@@ design/ryc_out_if.sv @@
// Output channel of the converter: one converted pixel pair and its frame-end flag.
// Uses ryc_pkg for the byte type.
`default_nettype none

interface ryc_out_if;
	logic valid;
	logic ready;
	ryc_pkg::pix_t out_0;
	ryc_pkg::pix_t out_1;
	ryc_pkg::pix_t out_2;
	ryc_pkg::pix_t out_3;
	ryc_pkg::pix_t out_4;
	ryc_pkg::pix_t out_5;
	logic frame_end_out;

	modport source (output valid, out_0, out_1, out_2, out_3, out_4, out_5,
		frame_end_out, input ready);
	modport sink (input valid, out_0, out_1, out_2, out_3, out_4, out_5,
		frame_end_out, output ready);
endinterface

`default_nettype wire

@@ design/rgb888_uyvy_color_converter_top.sv @@
// RGB888 / UYVY pixel pair converter, top level with handshake and registers.
// Uses ryc_pkg, ryc_in_if, ryc_out_if and ryc_convert.
//
// Takes one pixel pair per clock and returns one converted pair per clock.
// A pair passes through the input register and then the result register,
// with the fixed-point channel math between them. Direction 0 turns RGB888
// pairs into UYVY (U from pixel A, V from pixel B, out_4 and out_5 zero),
// direction 1 turns UYVY into two RGB888 pixels. Results are rounded half
// up and clamped to 0..255; frame_end rides along unchanged.
// Write the direction only while no pair is in flight. Throughput drops
// below one pair per clock only when the output side holds ready low.
`default_nettype none

module rgb888_uyvy_color_converter_top #(
	parameter int COEF_FRAC_BITS = 12
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	ryc_in_if.sink     upstream,
	ryc_out_if.source  downstream
);

	logic direction_q;

	logic           v_s1;
	ryc_pkg::pair_t pair_s1;
	logic           fe_s1;

	logic           v_s2;
	ryc_pkg::pair_t res_s2;
	logic           fe_s2;

	ryc_pkg::pair_t res;
	logic           adv_s2;
	logic           adv_s1;

	assign adv_s2 = !v_s2 || downstream.ready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign upstream.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= ryc_pkg::DIR_RGB_TO_UYVY;
		end else if (cfg_we) begin
			direction_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= upstream.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && upstream.valid) begin
			pair_s1 <= '{upstream.in_5, upstream.in_4, upstream.in_3,
				upstream.in_2, upstream.in_1, upstream.in_0};
			fe_s1 <= upstream.frame_end;
		end
		if (adv_s2 && v_s1) begin
			res_s2 <= res;
			fe_s2 <= fe_s1;
		end
	end

	ryc_convert #(.FRAC_BITS(COEF_FRAC_BITS)) u_convert (
		.dir  (direction_q),
		.pair (pair_s1),
		.res  (res)
	);

	assign downstream.valid = v_s2;
	assign downstream.out_0 = res_s2[0];
	assign downstream.out_1 = res_s2[1];
	assign downstream.out_2 = res_s2[2];
	assign downstream.out_3 = res_s2[3];
	assign downstream.out_4 = res_s2[4];
	assign downstream.out_5 = res_s2[5];
	assign downstream.frame_end_out = fe_s2;

endmodule

`default_nettype wire

@@ design/ryc_dot3.sv @@
// One color channel: three constant-coefficient products plus offset,
// rounded half up, scaled down and clamped to a byte. Uses ryc_pkg.
`default_nettype none

module ryc_dot3 #(
	parameter int FRAC_BITS = 12,
	parameter longint K0 = 0,
	parameter longint K1 = 0,
	parameter longint K2 = 0,
	parameter longint OFS = 0
) (
	input  ryc_pkg::pix_t x0,
	input  ryc_pkg::pix_t x1,
	input  ryc_pkg::pix_t x2,
	output ryc_pkg::pix_t y
);

	// |sum| stays below 2^(FRAC_BITS+11): coefficients under 2, offsets under 256
	localparam int SW = FRAC_BITS + 12;
	localparam int IW = SW - FRAC_BITS;
	localparam longint HALF = longint'(1) << (FRAC_BITS - 1);

	logic signed [SW-1:0] p0;
	logic signed [SW-1:0] p1;
	logic signed [SW-1:0] p2;
	logic signed [SW-1:0] sum;
	logic [IW-1:0] whole;

	assign p0 = $signed(SW'(K0)) * $signed({{(SW-ryc_pkg::PIX_W){1'b0}}, x0});
	assign p1 = $signed(SW'(K1)) * $signed({{(SW-ryc_pkg::PIX_W){1'b0}}, x1});
	assign p2 = $signed(SW'(K2)) * $signed({{(SW-ryc_pkg::PIX_W){1'b0}}, x2});
	assign sum = p0 + p1 + p2 + $signed(SW'(OFS + HALF));
	assign whole = sum[SW-1:FRAC_BITS];

	always_comb begin
		priority if (sum[SW-1]) begin
			y = '0;
		end else if (|whole[IW-2:ryc_pkg::PIX_W]) begin
			y = '1;
		end else begin
			y = whole[ryc_pkg::PIX_W-1:0];
		end
	end

endmodule

`default_nettype wire

@@ design/ryc_convert.sv @@
// Pair conversion datapath for both directions and the output select.
// Uses ryc_pkg and ryc_dot3.
`default_nettype none

module ryc_convert #(
	parameter int FRAC_BITS = 12
) (
	input  logic          dir,
	input  ryc_pkg::pair_t pair,
	output ryc_pkg::pair_t res
);

	localparam longint ONE = longint'(1) << FRAC_BITS;

	// Coefficients, round half up to FRAC_BITS fraction bits
	localparam longint K_Y_R = (longint'(299) * ONE + 500) / 1000;
	localparam longint K_Y_G = (longint'(587) * ONE + 500) / 1000;
	localparam longint K_Y_B = (longint'(114) * ONE + 500) / 1000;
	localparam longint K_U_R = (longint'(169) * ONE + 500) / 1000;
	localparam longint K_U_G = (longint'(331) * ONE + 500) / 1000;
	localparam longint K_UV_P = (longint'(499) * ONE + 500) / 1000;
	localparam longint K_V_G = (longint'(418) * ONE + 500) / 1000;
	localparam longint K_V_B = (longint'(813) * ONE + 5000) / 10000;
	localparam longint K_C_OFS = longint'(128) * ONE;
	localparam longint K_R_Y = (longint'(997) * ONE + 500) / 1000;
	localparam longint K_R_U = (longint'(7) * ONE + 500) / 1000;
	localparam longint K_R_V = (longint'(1405) * ONE + 500) / 1000;
	localparam longint K_R_OFS = (longint'(189114) * ONE + 500) / 1000;
	localparam longint K_G_U = (longint'(343) * ONE + 500) / 1000;
	localparam longint K_G_V = (longint'(716) * ONE + 500) / 1000;
	localparam longint K_G_OFS = (longint'(135460) * ONE + 500) / 1000;
	localparam longint K_B_Y = (longint'(1006) * ONE + 500) / 1000;
	localparam longint K_B_U = (longint'(1780) * ONE + 500) / 1000;
	localparam longint K_B_OFS = (longint'(227810) * ONE + 500) / 1000;

	ryc_pkg::pix_t u_a, y_a, v_b, y_b;
	ryc_pkg::pix_t r_a, g_a, b_a, r_b, g_b, b_b;

	// RGB888 to UYVY: chroma from one pixel each, no averaging
	ryc_dot3 #(.FRAC_BITS(FRAC_BITS), .K0(-K_U_R), .K1(-K_U_G), .K2(K_UV_P), .OFS(K_C_OFS))
		u_chan_u (.x0(pair[0]), .x1(pair[1]), .x2(pair[2]), .y(u_a));
	ryc_dot3 #(.FRAC_BITS(FRAC_BITS), .K0(K_Y_R), .K1(K_Y_G), .K2(K_Y_B), .OFS(0))
		u_chan_ya (.x0(pair[0]), .x1(pair[1]), .x2(pair[2]), .y(y_a));
	ryc_dot3 #(.FRAC_BITS(FRAC_BITS), .K0(K_UV_P), .K1(-K_V_G), .K2(-K_V_B), .OFS(K_C_OFS))
		u_chan_v (.x0(pair[3]), .x1(pair[4]), .x2(pair[5]), .y(v_b));
	ryc_dot3 #(.FRAC_BITS(FRAC_BITS), .K0(K_Y_R), .K1(K_Y_G), .K2(K_Y_B), .OFS(0))
		u_chan_yb (.x0(pair[3]), .x1(pair[4]), .x2(pair[5]), .y(y_b));

	// UYVY to RGB888: bytes are U, Y_A, V, Y_B; inputs ordered Y, U, V
	ryc_dot3 #(.FRAC_BITS(FRAC_BITS), .K0(K_R_Y), .K1(-K_R_U), .K2(K_R_V), .OFS(-K_R_OFS))
		u_chan_ra (.x0(pair[1]), .x1(pair[0]), .x2(pair[2]), .y(r_a));
	ryc_dot3 #(.FRAC_BITS(FRAC_BITS), .K0(ONE), .K1(-K_G_U), .K2(-K_G_V), .OFS(K_G_OFS))
		u_chan_ga (.x0(pair[1]), .x1(pair[0]), .x2(pair[2]), .y(g_a));
	ryc_dot3 #(.FRAC_BITS(FRAC_BITS), .K0(K_B_Y), .K1(K_B_U), .K2(0), .OFS(-K_B_OFS))
		u_chan_ba (.x0(pair[1]), .x1(pair[0]), .x2(pair[2]), .y(b_a));
	ryc_dot3 #(.FRAC_BITS(FRAC_BITS), .K0(K_R_Y), .K1(-K_R_U), .K2(K_R_V), .OFS(-K_R_OFS))
		u_chan_rb (.x0(pair[3]), .x1(pair[0]), .x2(pair[2]), .y(r_b));
	ryc_dot3 #(.FRAC_BITS(FRAC_BITS), .K0(ONE), .K1(-K_G_U), .K2(-K_G_V), .OFS(K_G_OFS))
		u_chan_gb (.x0(pair[3]), .x1(pair[0]), .x2(pair[2]), .y(g_b));
	ryc_dot3 #(.FRAC_BITS(FRAC_BITS), .K0(K_B_Y), .K1(K_B_U), .K2(0), .OFS(-K_B_OFS))
		u_chan_bb (.x0(pair[3]), .x1(pair[0]), .x2(pair[2]), .y(b_b));

	always_comb begin
		unique case (dir)
			ryc_pkg::DIR_RGB_TO_UYVY: begin
				res = '{'0, '0, y_b, v_b, y_a, u_a};
			end
			ryc_pkg::DIR_UYVY_TO_RGB: begin
				res = '{b_b, g_b, r_b, b_a, g_a, r_a};
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/ryc_checker.sv @@
// Port-level checks for the converter top, attached by bind.
// Uses rgb888_uyvy_color_converter_top_macros.svh.
`default_nettype none
`include "rgb888_uyvy_color_converter_top_macros.svh"

module ryc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        up_valid,
	input wire logic        up_ready,
	input wire logic        dn_valid,
	input wire logic        dn_ready,
	input wire logic [48:0] dn_data
);

	logic up_xfer;

	assign up_xfer = up_valid && up_ready;

	// Stalled result holds its value
	`RYC_ASSERT_NEXT(a_dn_hold, clk, arst_n, dn_valid && !dn_ready, dn_valid && $stable(dn_data))

	// Input side never stalls when the result slot is free or draining
	`RYC_ASSERT_NOW(a_up_ready, clk, arst_n, !dn_valid || dn_ready, up_ready)

	// From an empty output, a result shows exactly when a transfer in has passed the input and result registers
	`RYC_ASSERT_NEXT(a_latency, clk, arst_n, !dn_valid && $past(arst_n), dn_valid == $past(up_xfer, 2))

endmodule

bind rgb888_uyvy_color_converter_top ryc_checker u_ryc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.up_valid (upstream.valid),
	.up_ready (upstream.ready),
	.dn_valid (downstream.valid),
	.dn_ready (downstream.ready),
	.dn_data  ({downstream.frame_end_out, downstream.out_5, downstream.out_4,
		downstream.out_3, downstream.out_2, downstream.out_1, downstream.out_0})
);

`default_nettype wire

@@ tb/ryc_pair_checker.sv @@
// Scoreboard for the RGB888 / UYVY pixel pair converter: watches both channels and the
// direction register port, predicts each converted pair in Q-format fixed point and compares.
// Depends on ryc_pkg, ryc_in_if and ryc_out_if.
module ryc_pair_checker #(
	parameter int COEF_FRAC_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	ryc_in_if    up,
	ryc_out_if   dn,
	output int   errors,
	output int   pending,
	output int   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import ryc_pkg::*;

	localparam longint ONE = longint'(1) << COEF_FRAC_BITS;

	typedef struct {
		pair_t bytes;
		logic  frame_end;
	} conv_pair_t;

	conv_pair_t expected_pairs[$];
	logic direction;

	// Coefficient num/den in fixed point, rounded half up
	function automatic longint fx(longint num, longint den);
		return (num * ONE + den / 2) / den;
	endfunction

	function automatic pix_t round_clamp(longint acc);
		longint t;
		t = acc + ONE / 2;
		if (t < 0)
			return '0;
		t = t >>> COEF_FRAC_BITS;
		if (t > 255)
			return 8'hFF;
		return pix_t'(t);
	endfunction

	function automatic pix_t luma(longint r, longint g, longint b);
		return round_clamp(fx(299, 1000) * r + fx(587, 1000) * g + fx(114, 1000) * b);
	endfunction

	function automatic pix_t chroma_u(longint r, longint g, longint b);
		return round_clamp(-fx(169, 1000) * r - fx(331, 1000) * g + fx(499, 1000) * b
			+ fx(128, 1));
	endfunction

	function automatic pix_t chroma_v(longint r, longint g, longint b);
		return round_clamp(fx(499, 1000) * r - fx(418, 1000) * g - fx(813, 10000) * b
			+ fx(128, 1));
	endfunction

	function automatic pix_t red_of(longint y, longint u, longint v);
		return round_clamp(fx(997, 1000) * y - fx(7, 1000) * u + fx(1405, 1000) * v
			- fx(189114, 1000));
	endfunction

	function automatic pix_t green_of(longint y, longint u, longint v);
		return round_clamp(fx(1, 1) * y - fx(343, 1000) * u - fx(716, 1000) * v
			+ fx(135460, 1000));
	endfunction

	function automatic pix_t blue_of(longint y, longint u);
		return round_clamp(fx(1006, 1000) * y + fx(1780, 1000) * u - fx(227810, 1000));
	endfunction

	function automatic conv_pair_t convert(pair_t src, logic fe, logic dir);
		longint a[PAIR_BYTES];
		conv_pair_t res;
		for (int k = 0; k < PAIR_BYTES; k++)
			a[k] = longint'(src[k]);
		if (dir == DIR_RGB_TO_UYVY) begin
			res.bytes[0] = chroma_u(a[0], a[1], a[2]);
			res.bytes[1] = luma(a[0], a[1], a[2]);
			res.bytes[2] = chroma_v(a[3], a[4], a[5]);
			res.bytes[3] = luma(a[3], a[4], a[5]);
			res.bytes[4] = '0;
			res.bytes[5] = '0;
		end else begin
			// shared U (byte 0) and V (byte 2) for both pixels
			res.bytes[0] = red_of(a[1], a[0], a[2]);
			res.bytes[1] = green_of(a[1], a[0], a[2]);
			res.bytes[2] = blue_of(a[1], a[0]);
			res.bytes[3] = red_of(a[3], a[0], a[2]);
			res.bytes[4] = green_of(a[3], a[0], a[2]);
			res.bytes[5] = blue_of(a[3], a[0]);
		end
		res.frame_end = fe;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		conv_pair_t want;
		pair_t got;
		if (!arst_n) begin
			direction <= DIR_RGB_TO_UYVY;
			expected_pairs.delete();
			pending <= 0;
			errors = 0;
			checked = 0;
		end else begin
			if (cfg_we)
				direction <= cfg_wdata;
			if (up.valid && up.ready)
				expected_pairs.push_back(convert({up.in_5, up.in_4, up.in_3, up.in_2,
					up.in_1, up.in_0}, up.frame_end, direction));
			if (dn.valid && dn.ready) begin
				got = {dn.out_5, dn.out_4, dn.out_3, dn.out_2, dn.out_1, dn.out_0};
				if (expected_pairs.size() == 0) begin
					errors++;
					$error("output transfer with no pair outstanding: %h", got);
				end else begin
					want = expected_pairs.pop_front();
					checked++;
					for (int k = 0; k < PAIR_BYTES; k++) begin
						if (got[k] !== want.bytes[k]) begin
							errors++;
							$error("out_%0d: expected %0d, got %0d", k, want.bytes[k], got[k]);
						end
					end
					if (dn.frame_end_out !== want.frame_end) begin
						errors++;
						$error("frame_end_out: expected %0d, got %0d", want.frame_end,
							dn.frame_end_out);
					end
				end
			end
			pending <= expected_pairs.size();
		end
	end

endmodule

@@ tb/tb_rgb888_uyvy_color_converter_top.sv @@
// Testbench top for the RGB888 / UYVY pixel pair converter: clock, reset, direction writes,
// directed and random pixel pairs with random gaps and output stalls, watchdog and verdict.
// Depends on ryc_pkg, ryc_in_if, ryc_out_if, ryc_pair_checker and the converter top.
module tb_rgb888_uyvy_color_converter_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ryc_pkg::*;

	localparam int FRAC_BITS = 12;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PAIRS = 750;
	localparam int PHASES = 6;
	// Direction per random phase, bit n for phase n
	localparam logic [PHASES-1:0] PHASE_DIRS = 6'b100110;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	ryc_in_if  up_ch ();
	ryc_out_if dn_ch ();

	int errors;
	int pending;
	int checked;
	int rgb_pairs;
	int uyvy_pairs;
	int frame_ends;
	bit steady;
	logic cur_dir;

	rgb888_uyvy_color_converter_top #(
		.COEF_FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.upstream(up_ch),
		.downstream(dn_ch)
	);

	ryc_pair_checker #(
		.COEF_FRAC_BITS(FRAC_BITS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.up(up_ch),
		.dn(dn_ch),
		.errors(errors),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, a few long ones; none in steady stretches
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic pix_t random_byte();
		case ($urandom_range(0, 15))
			0: return 8'h00;
			1: return 8'hFF;
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		for (int k = 0; k < PAIR_BYTES; k++)
			p[k] = random_byte();
		return p;
	endfunction

	function automatic pair_t mk(pix_t b0, pix_t b1, pix_t b2, pix_t b3, pix_t b4, pix_t b5);
		return {b5, b4, b3, b2, b1, b0};
	endfunction

	task automatic write_direction(logic dir);
		cfg_we <= 1'b1;
		cfg_wdata <= dir;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_dir = dir;
	endtask

	// Hold off until every outstanding pair has come back
	task automatic drain();
		up_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic send_pair(pair_t d, logic fe);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			up_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		up_ch.valid <= 1'b1;
		up_ch.in_0 <= d[0];
		up_ch.in_1 <= d[1];
		up_ch.in_2 <= d[2];
		up_ch.in_3 <= d[3];
		up_ch.in_4 <= d[4];
		up_ch.in_5 <= d[5];
		up_ch.frame_end <= fe;
		do @(posedge clk); while (!up_ch.ready);
		if (cur_dir == DIR_RGB_TO_UYVY)
			rgb_pairs++;
		else
			uyvy_pairs++;
		if (fe)
			frame_ends++;
	endtask

	// Output side back-pressure
	initial begin
		int n;
		dn_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			dn_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			n = idle_len();
			if (n > 0) begin
				dn_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n);
		do begin
			@(posedge clk);
			if ((up_ch.valid && up_ch.ready) || (dn_ch.valid && dn_ch.ready))
				quiet = 0;
			else
				quiet++;
		end while (quiet < STALL_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		steady = 1'b0;
		cur_dir = DIR_RGB_TO_UYVY;
		rgb_pairs = 0;
		uyvy_pairs = 0;
		frame_ends = 0;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		up_ch.valid <= 1'b0;
		up_ch.in_0 <= '0;
		up_ch.in_1 <= '0;
		up_ch.in_2 <= '0;
		up_ch.in_3 <= '0;
		up_ch.in_4 <= '0;
		up_ch.in_5 <= '0;
		up_ch.frame_end <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// RGB888 to UYVY: extremes, bit patterns, primaries
		write_direction(DIR_RGB_TO_UYVY);
		send_pair(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
		send_pair(mk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1);
		send_pair(mk(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55), 1'b0);
		send_pair(mk(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA), 1'b0);
		send_pair(mk(8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00), 1'b0);
		send_pair(mk(8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00), 1'b0);
		send_pair(mk(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF), 1'b1);

		// UYVY to RGB888: clamping at both ends, unused bytes nonzero
		drain();
		write_direction(DIR_UYVY_TO_RGB);
		send_pair(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
		send_pair(mk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1);
		send_pair(mk(8'h00, 8'h00, 8'hFF, 8'hFF, 8'hA5, 8'h5A), 1'b0);
		send_pair(mk(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h5A, 8'hA5), 1'b0);
		send_pair(mk(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hC3, 8'h3C), 1'b0);
		send_pair(mk(8'h80, 8'h80, 8'h80, 8'h10, 8'h3C, 8'hC3), 1'b0);
		send_pair(mk(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55), 1'b1);

		// Random phases; each starts from an empty pipeline with a fresh direction write
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_direction(PHASE_DIRS[ph]);
			steady = (ph == 2);
			repeat (RANDOM_PAIRS / PHASES)
				send_pair(random_pair(), $urandom_range(0, 15) == 0);
		end

		steady = 1'b0;
		drain();
		repeat (20) @(posedge clk);

		$display("Converted %0d RGB888->UYVY and %0d UYVY->RGB888 pairs (%0d frame ends),",
			rgb_pairs, uyvy_pairs, frame_ends);
		$display("%0d results compared, %0d mismatches, %0d still outstanding",
			checked, errors, pending);
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
